// ===== design/assert_macros.svh =====
// Assertion macros for the RTL file that checks itself.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge outside reset.
`define QMAD_ASSERT_IMP(label, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// Check an implication in the next cycle.
`define QMAD_ASSERT_NEXT(label, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

// ===== design/qmad_pkg.sv =====
// Shared types, codes and probability tables of the QM arithmetic decoder.
// No dependencies.
`default_nettype none

package qmad_pkg;

    localparam int NumStates = 113;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_PUSH   = 2'd1,
        OP_DECODE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NEED   = 2'd1,
        ST_FULL   = 2'd2,
        ST_MARKER = 2'd3
    } status_t;

    // Controller to datapath.
    typedef struct packed {
        logic load_item;
        logic exec;
        logic shift;
    } qmad_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic exec_shift;
        logic shift_last;
    } qmad_stat_t;

    localparam logic [15:0] QE_TAB [NumStates] = '{
        16'h5A1D, 16'h2586, 16'h1114, 16'h080B, 16'h03D8, 16'h01DA, 16'h00E5, 16'h006F,
        16'h0036, 16'h001A, 16'h000D, 16'h0006, 16'h0003, 16'h0001, 16'h5A7F, 16'h3F25,
        16'h2CF2, 16'h207C, 16'h17B9, 16'h1182, 16'h0CEF, 16'h09A1, 16'h072F, 16'h055C,
        16'h0406, 16'h0303, 16'h0240, 16'h01B1, 16'h0144, 16'h00F5, 16'h00B7, 16'h008A,
        16'h0068, 16'h004E, 16'h003B, 16'h002C, 16'h5AE1, 16'h484C, 16'h3A0D, 16'h2EF1,
        16'h261F, 16'h1F33, 16'h19A8, 16'h1518, 16'h1177, 16'h0E74, 16'h0BFB, 16'h09F8,
        16'h0861, 16'h0706, 16'h05CD, 16'h04DE, 16'h040F, 16'h0363, 16'h02D4, 16'h025C,
        16'h01F8, 16'h01A4, 16'h0160, 16'h0125, 16'h00F6, 16'h00CB, 16'h00AB, 16'h008F,
        16'h5B12, 16'h4D04, 16'h412C, 16'h37D8, 16'h2FE8, 16'h293C, 16'h2379, 16'h1EDF,
        16'h1AA9, 16'h174E, 16'h1424, 16'h119C, 16'h0F6B, 16'h0D51, 16'h0BB6, 16'h0A40,
        16'h5832, 16'h4D1C, 16'h438E, 16'h3BDD, 16'h34EE, 16'h2EAE, 16'h299A, 16'h2516,
        16'h5570, 16'h4CA9, 16'h44D9, 16'h3E22, 16'h3824, 16'h32B4, 16'h2E17, 16'h56A8,
        16'h4F46, 16'h47E5, 16'h41CF, 16'h3C3D, 16'h375E, 16'h5231, 16'h4C0F, 16'h4639,
        16'h415E, 16'h5627, 16'h50E7, 16'h4B85, 16'h5597, 16'h504F, 16'h5A10, 16'h5522,
        16'h59EB};

    localparam logic [6:0] NLPS_TAB [NumStates] = '{
        7'd1,   7'd14,  7'd16,  7'd18,  7'd20,  7'd23,  7'd25,  7'd28,  7'd30,  7'd33,
        7'd35,  7'd9,   7'd10,  7'd12,  7'd15,  7'd36,  7'd38,  7'd39,  7'd40,  7'd42,
        7'd43,  7'd45,  7'd46,  7'd48,  7'd49,  7'd51,  7'd52,  7'd54,  7'd56,  7'd57,
        7'd59,  7'd60,  7'd62,  7'd63,  7'd32,  7'd33,  7'd37,  7'd64,  7'd65,  7'd67,
        7'd68,  7'd69,  7'd70,  7'd72,  7'd73,  7'd74,  7'd75,  7'd77,  7'd78,  7'd79,
        7'd48,  7'd50,  7'd50,  7'd51,  7'd52,  7'd53,  7'd54,  7'd55,  7'd56,  7'd57,
        7'd58,  7'd59,  7'd61,  7'd61,  7'd65,  7'd80,  7'd81,  7'd82,  7'd83,  7'd84,
        7'd86,  7'd87,  7'd87,  7'd72,  7'd72,  7'd74,  7'd74,  7'd75,  7'd77,  7'd77,
        7'd80,  7'd88,  7'd89,  7'd90,  7'd91,  7'd92,  7'd93,  7'd86,  7'd88,  7'd95,
        7'd96,  7'd97,  7'd99,  7'd99,  7'd93,  7'd95,  7'd101, 7'd102, 7'd103, 7'd104,
        7'd99,  7'd105, 7'd106, 7'd107, 7'd103, 7'd105, 7'd108, 7'd109, 7'd110, 7'd111,
        7'd110, 7'd112, 7'd112};

    localparam logic [6:0] NMPS_TAB [NumStates] = '{
        7'd1,   7'd2,   7'd3,   7'd4,   7'd5,   7'd6,   7'd7,   7'd8,   7'd9,   7'd10,
        7'd11,  7'd12,  7'd13,  7'd13,  7'd15,  7'd16,  7'd17,  7'd18,  7'd19,  7'd20,
        7'd21,  7'd22,  7'd23,  7'd24,  7'd25,  7'd26,  7'd27,  7'd28,  7'd29,  7'd30,
        7'd31,  7'd32,  7'd33,  7'd34,  7'd35,  7'd9,   7'd37,  7'd38,  7'd39,  7'd40,
        7'd41,  7'd42,  7'd43,  7'd44,  7'd45,  7'd46,  7'd47,  7'd48,  7'd49,  7'd50,
        7'd51,  7'd52,  7'd53,  7'd54,  7'd55,  7'd56,  7'd57,  7'd58,  7'd59,  7'd60,
        7'd61,  7'd62,  7'd63,  7'd32,  7'd65,  7'd66,  7'd67,  7'd68,  7'd69,  7'd70,
        7'd71,  7'd72,  7'd73,  7'd74,  7'd75,  7'd76,  7'd77,  7'd78,  7'd79,  7'd48,
        7'd81,  7'd82,  7'd83,  7'd84,  7'd85,  7'd86,  7'd87,  7'd71,  7'd89,  7'd90,
        7'd91,  7'd92,  7'd93,  7'd94,  7'd86,  7'd96,  7'd97,  7'd98,  7'd99,  7'd100,
        7'd93,  7'd102, 7'd103, 7'd104, 7'd99,  7'd106, 7'd107, 7'd103, 7'd109, 7'd107,
        7'd111, 7'd109, 7'd111};

    // States whose LPS path exchanges the sense of the MPS.
    localparam logic [NumStates-1:0] SWITCH_MASK =
        (NumStates'(1) << 0)   | (NumStates'(1) << 14)  | (NumStates'(1) << 36)  |
        (NumStates'(1) << 64)  | (NumStates'(1) << 80)  | (NumStates'(1) << 88)  |
        (NumStates'(1) << 95)  | (NumStates'(1) << 105) | (NumStates'(1) << 110) |
        (NumStates'(1) << 112);

    // Count leading zeros of a 16-bit interval, capped at 16.
    function automatic logic [4:0] lead_zeros(input logic [15:0] v);
        logic [4:0] n;
        logic       found;
        n     = 5'd0;
        found = 1'b0;
        for (int i = 15; i >= 0; i--)
        begin
            if (!found && !v[i])
                n = n + 5'd1;
            else
                found = 1'b1;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== design/qmad_if.sv =====
// Valid/ready channel interfaces for the decoder's command and result streams.
// No dependencies.
`default_nettype none

interface qmad_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] byte_value;

    modport source (output valid, output operation, output byte_value, input ready);
    modport sink   (input valid, input operation, input byte_value, output ready);
endinterface

interface qmad_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       bit_valid;
    logic       decoded_bit;
    logic [7:0] marker_code;

    modport source (output valid, output status, output bit_valid, output decoded_bit,
                    output marker_code, input ready);
    modport sink   (input valid, input status, input bit_valid, input decoded_bit,
                    input marker_code, output ready);
endinterface

`default_nettype wire

// ===== design/qm_binary_arithmetic_decoder.sv =====
// Single-context QM binary arithmetic decoder (top level).
// One command in, one result out per command; one command in flight at a time.
// Input channel in_ch: operation (start, push byte, decode) and byte_value.
// Output channel out_ch: status, bit_valid, decoded_bit, marker_code.
// A start or push command goes from acceptance through the execute state to its result;
// a decode also passes the renormalize state when its shift count n (0..16) is nonzero,
// as the shifter moves one bit per cycle. The next command is taken in the cycle after
// the result transfers.
// Reset clears the probability state, sets the interval to 0x10000, empties
// the bit buffer and clears the marker flags; a start command does the same.
// While the receiver stalls, the result is held and in_ch.ready stays low.
// BUFFER_BITS sets the depth of the bit buffer (32 to 64).
// Depends on qmad_pkg, qmad_if, qmad_ctrl, qmad_datapath and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module qm_binary_arithmetic_decoder
    import qmad_pkg::*;
#(
    parameter int BUFFER_BITS = 32
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    qmad_in_if.sink   in_ch,
    qmad_out_if.source out_ch
);

    qmad_cmd_t  cmd;
    qmad_stat_t stat;

    // Sequence each command through execute and renormalize.
    qmad_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Hold the decoder state and compute the result.
    qmad_datapath #(
        .BUFFER_BITS (BUFFER_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .operation   (in_ch.operation),
        .byte_value  (in_ch.byte_value),
        .stat        (stat),
        .status      (out_ch.status),
        .bit_valid   (out_ch.bit_valid),
        .decoded_bit (out_ch.decoded_bit),
        .marker_code (out_ch.marker_code)
    );

    `QMAD_ASSERT_IMP(a_one_in_flight, out_ch.valid, !in_ch.ready, "input taken while result pending")
    `QMAD_ASSERT_IMP(a_bit_ok, out_ch.valid && out_ch.bit_valid, out_ch.status == ST_OK, "bit with bad status")
    `QMAD_ASSERT_IMP(a_code_marker, out_ch.valid && out_ch.marker_code != 8'd0, out_ch.status == ST_MARKER, "marker code without marker")
    `QMAD_ASSERT_NEXT(a_accept_busy, in_ch.valid && in_ch.ready, !in_ch.ready && !out_ch.valid, "accept did not start work")

endmodule

`default_nettype wire

// ===== design/qmad_ctrl.sv =====
// Sequencer of the QM decoder: accept, execute, renormalize, deliver.
// Depends on qmad_pkg.
`default_nettype none

module qmad_ctrl
    import qmad_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire qmad_stat_t stat,
    output qmad_cmd_t       cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg, in_ready_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_EXEC;
            S_EXEC:  state_next = stat.exec_shift ? S_SHIFT : S_DONE;
            S_SHIFT: if (stat.shift_last) state_next = S_DONE;
            S_DONE:  if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        in_ready_next  = (state_next == S_IDLE);
        out_valid_next = (state_next == S_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= in_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready      = in_ready_reg;
    assign out_valid     = out_valid_reg;
    assign cmd.load_item = in_ready_reg && in_valid;
    assign cmd.exec      = (state_reg == S_EXEC);
    assign cmd.shift     = (state_reg == S_SHIFT);

endmodule

`default_nettype wire

// ===== design/qmad_datapath.sv =====
// Datapath of the QM decoder: byte unstuffing, bit buffer, interval and code
// registers, probability state and the one-bit-a-cycle renormalizer. Uses qmad_pkg.
`default_nettype none

module qmad_datapath
    import qmad_pkg::*;
#(
    parameter int BUFFER_BITS = 32
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire qmad_cmd_t  cmd,
    input  wire logic [1:0] operation,
    input  wire logic [7:0] byte_value,
    output qmad_stat_t      stat,
    output logic [1:0]      status,
    output logic            bit_valid,
    output logic            decoded_bit,
    output logic [7:0]      marker_code
);

    localparam int CW = $clog2(BUFFER_BITS + 1);
    localparam int IW = $clog2(BUFFER_BITS);

    logic [1:0]             op_reg;
    logic [7:0]             byte_reg;
    logic [6:0]             idx_reg;
    logic                   mps_reg;
    logic [16:0]            a_reg;
    logic [15:0]            c_reg;
    logic [BUFFER_BITS-1:0] buf_reg;
    logic [CW-1:0]          cnt_reg;
    logic                   ffp_reg, mks_reg, loaded_reg;
    logic [4:0]             sh_reg;
    logic [1:0]             st_reg;
    logic                   bv_reg, bit_reg;
    logic [7:0]             mc_reg;

    // Decode evaluation.
    logic [6:0]   idx_e;
    logic [15:0]  qe;
    logic [16:0]  a_sub, a_new;
    logic [15:0]  c0, c_new, peek16;
    logic         d, mps_new, renorm, fail;
    logic [6:0]   idx_new;
    logic [4:0]   n;
    logic [5:0]   need;
    logic         lps;
    logic         room;
    logic         peek1;
    logic [IW-1:0] top_pos;
    logic [CW-1:0] cnt_dec;

    always_comb
    begin
        idx_e = (idx_reg < 7'(NumStates)) ? idx_reg : 7'd0;
        qe    = QE_TAB[idx_e];
        if (cnt_reg >= CW'(16))
            peek16 = 16'(buf_reg >> (cnt_reg - CW'(16)));
        else
            peek16 = 16'(buf_reg << (CW'(16) - cnt_reg));
        c0     = loaded_reg ? c_reg : peek16;
        a_sub  = a_reg - {1'b0, qe};
        c_new  = c0;
        renorm = 1'b1;
        if ({1'b0, c0} < a_sub)
        begin
            a_new = a_sub;
            lps   = a_sub < {1'b0, qe};
            if (a_sub >= 17'h08000)
                renorm = 1'b0;
        end
        else
        begin
            c_new = 16'({1'b0, c0} - a_sub);
            a_new = {1'b0, qe};
            lps   = !(a_sub < {1'b0, qe});
        end
        if (!renorm)
        begin
            d       = mps_reg;
            mps_new = mps_reg;
            idx_new = idx_reg;
        end
        else if (lps)
        begin
            d       = !mps_reg;
            mps_new = mps_reg ^ SWITCH_MASK[idx_e];
            idx_new = NLPS_TAB[idx_e];
        end
        else
        begin
            d       = mps_reg;
            mps_new = mps_reg;
            idx_new = NMPS_TAB[idx_e];
        end
        n    = renorm ? lead_zeros(a_new[15:0]) : 5'd0;
        need = {1'b0, n} + (loaded_reg ? 6'd0 : 6'd16);
        fail = !mks_reg && ({1'b0, cnt_reg} < (CW + 1)'(need));
        room = ({1'b0, cnt_reg} + (CW + 1)'(8)) <= (CW + 1)'(BUFFER_BITS);

        cnt_dec = cnt_reg - CW'(1);
        top_pos = cnt_dec[IW-1:0];
        peek1   = (cnt_reg != '0) ? buf_reg[top_pos] : 1'b0;
    end

    assign stat.exec_shift = (op_t'(op_reg) == OP_DECODE) && !fail && (n != 5'd0);
    assign stat.shift_last = (sh_reg == 5'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= 7'd0;
            mps_reg    <= 1'b0;
            a_reg      <= 17'h10000;
            c_reg      <= 16'd0;
            buf_reg    <= '0;
            cnt_reg    <= '0;
            ffp_reg    <= 1'b0;
            mks_reg    <= 1'b0;
            loaded_reg <= 1'b0;
            sh_reg     <= 5'd0;
        end
        else if (cmd.exec)
        begin
            unique case (op_t'(op_reg))
                OP_START:
                begin
                    idx_reg    <= 7'd0;
                    mps_reg    <= 1'b0;
                    a_reg      <= 17'h10000;
                    c_reg      <= 16'd0;
                    buf_reg    <= '0;
                    cnt_reg    <= '0;
                    ffp_reg    <= 1'b0;
                    mks_reg    <= 1'b0;
                    loaded_reg <= 1'b0;
                end
                OP_PUSH:
                begin
                    if (!mks_reg)
                    begin
                        if (ffp_reg)
                        begin
                            if (byte_reg == 8'h00)
                            begin
                                buf_reg <= BUFFER_BITS'({buf_reg, 8'hFF});
                                cnt_reg <= cnt_reg + CW'(8);
                                ffp_reg <= 1'b0;
                            end
                            else if (byte_reg != 8'hFF)
                            begin
                                ffp_reg <= 1'b0;
                                mks_reg <= 1'b1;
                            end
                        end
                        else if (room)
                        begin
                            if (byte_reg == 8'hFF)
                                ffp_reg <= 1'b1;
                            else
                            begin
                                buf_reg <= BUFFER_BITS'({buf_reg, byte_reg});
                                cnt_reg <= cnt_reg + CW'(8);
                            end
                        end
                    end
                end
                OP_DECODE:
                begin
                    if (!fail)
                    begin
                        idx_reg <= idx_new;
                        mps_reg <= mps_new;
                        a_reg   <= a_new;
                        c_reg   <= c_new;
                        sh_reg  <= n;
                        if (!loaded_reg)
                        begin
                            loaded_reg <= 1'b1;
                            cnt_reg    <= (cnt_reg >= CW'(16)) ? cnt_reg - CW'(16) : '0;
                        end
                    end
                end
                default: ;
            endcase
        end
        else if (cmd.shift)
        begin
            // Shift one bit into the code register; zeros once the buffer is dry.
            a_reg  <= {a_reg[15:0], 1'b0};
            c_reg  <= {c_reg[14:0], peek1};
            sh_reg <= sh_reg - 5'd1;
            if (cnt_reg != '0)
                cnt_reg <= cnt_dec;
        end
    end

    // Item and result holding registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg   <= operation;
            byte_reg <= byte_value;
        end
        if (cmd.exec)
        begin
            st_reg  <= ST_OK;
            bv_reg  <= 1'b0;
            bit_reg <= 1'b0;
            mc_reg  <= 8'd0;
            case (op_t'(op_reg))
                OP_PUSH:
                begin
                    if (mks_reg)
                        st_reg <= ST_MARKER;
                    else if (ffp_reg)
                    begin
                        if (byte_reg != 8'h00 && byte_reg != 8'hFF)
                        begin
                            st_reg <= ST_MARKER;
                            mc_reg <= byte_reg;
                        end
                    end
                    else if (!room)
                        st_reg <= ST_FULL;
                end
                OP_DECODE:
                begin
                    if (fail)
                        st_reg <= ST_NEED;
                    else
                    begin
                        bv_reg  <= 1'b1;
                        bit_reg <= d;
                    end
                end
                default: ;
            endcase
        end
    end

    assign status      = st_reg;
    assign bit_valid   = bv_reg;
    assign decoded_bit = bit_reg;
    assign marker_code = mc_reg;

endmodule

`default_nettype wire
